// File: sv/tlpq_pkg.sv
`default_nettype none

package tlpq_pkg;

    localparam int ID_W       = 16;
    localparam int TIME_W     = 32;
    localparam int LIVE_W     = 5;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_CANCEL = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // One stored queue entry.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              prio;
        logic [TIME_W-1:0] tstamp;
    } t_entry;

    // Controls broadcast from the sequencer to every cell.
    typedef struct packed {
        logic            tok_load;
        logic            tok_step;
        logic [ID_W-1:0] id;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: sv/tlpq_cell.sv
`default_nettype none

module tlpq_cell import tlpq_pkg::*; #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic             i_wr,
    input  wire t_entry           i_wr_ent,
    input  wire logic             i_shift,
    input  wire logic             i_nxt_vld,
    input  wire t_entry           i_nxt_ent,
    input  wire logic             i_nxt_tok_vld,
    input  wire t_entry           i_nxt_tok,
    input  wire logic [IDX_W-1:0] i_nxt_tok_idx,
    output logic                  o_vld,
    output t_entry                o_ent,
    output logic                  o_match,
    output logic                  o_tok_vld,
    output t_entry                o_tok,
    output logic [IDX_W-1:0]      o_tok_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic             r_vld;
    t_entry           r_ent;
    logic             r_tok_vld;
    t_entry           r_tok;
    logic [IDX_W-1:0] r_tok_idx;
    logic             w_take;

    // The neighbor's token covers later slots, so it wins only when strictly better.
    assign w_take = i_nxt_tok_vld &&
                    (!r_tok_vld ||
                     (i_nxt_tok.prio && !r_tok.prio) ||
                     ((i_nxt_tok.prio == r_tok.prio) && (i_nxt_tok.tstamp < r_tok.tstamp)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_tok_vld <= 1'b0;
        end else begin
            if (i_shift) begin
                r_vld <= i_nxt_vld;
            end else if (i_wr) begin
                r_vld <= 1'b1;
            end
            if (i_ctl.tok_load) begin
                r_tok_vld <= r_vld;
            end else if (i_ctl.tok_step && w_take) begin
                r_tok_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_ent <= i_nxt_ent;
        end else if (i_wr) begin
            r_ent <= i_wr_ent;
        end
        if (i_ctl.tok_load) begin
            r_tok     <= r_ent;
            r_tok_idx <= MY_IDX;
        end else if (i_ctl.tok_step && w_take) begin
            r_tok     <= i_nxt_tok;
            r_tok_idx <= i_nxt_tok_idx;
        end
    end

    assign o_vld     = r_vld;
    assign o_ent     = r_ent;
    assign o_match   = r_vld && (r_ent.id == i_ctl.id);
    assign o_tok_vld = r_tok_vld;
    assign o_tok     = r_tok;
    assign o_tok_idx = r_tok_idx;

endmodule

`default_nettype wire

// File: sv/two_level_priority_queue_cancel.sv
// Bounded priority queue with FIFO tie-break and cancel by id.
// Input channel: i_valid / o_stall carry a command (enqueue, dequeue best,
// cancel by id) with id, priority and timestamp; a transfer happens at a
// rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry exactly one result per command:
// status, the dequeued entry (zero unless a dequeue succeeded) and the live
// count after the command.
// Entries live in a chain of DEPTH cells, compacted in insertion order.
// Enqueue and cancel finish in the transfer cycle and their result shows in
// the cycle after; unless the receiver stalls they can follow one per cycle.
// A dequeue of a queue holding N entries runs a best-entry token down the
// cell chain one neighbor step per cycle; its result shows once the token
// has reached the chain head, and the next command is taken only after that.
// Removal shifts all later cells down by one place together.
// Reset empties the queue and drops any pending result.
// While the receiver stalls, the result register holds its value and the
// block takes no new command until the result transfer is done.
`default_nettype none

module two_level_priority_queue_cancel import tlpq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [CMD_W-1:0]  i_cmd,
    input  wire logic [ID_W-1:0]   i_order_id,
    input  wire logic              i_entry_priority,
    input  wire logic [TIME_W-1:0] i_entry_time,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [STATUS_W-1:0]    o_status,
    output logic [ID_W-1:0]        o_out_id,
    output logic                   o_out_priority,
    output logic [TIME_W-1:0]      o_out_time,
    output logic [LIVE_W-1:0]      o_live_count
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [CNT_W-1:0]     r_step;
    logic                 r_ovld;
    t_status              r_status;
    t_entry               r_out;
    logic [LIVE_W-1:0]    r_live;

    // Cell chain wiring; index DEPTH is the empty slot beyond the last cell.
    logic   [DEPTH:0]     w_vld;
    t_entry               w_ent [DEPTH+1];
    logic   [DEPTH:0]     w_tok_vld;
    t_entry               w_tok [DEPTH+1];
    logic   [IDX_W-1:0]   w_tok_idx [DEPTH+1];
    logic   [DEPTH-1:0]   w_match;
    logic   [DEPTH-1:0]   w_pre;
    logic   [DEPTH-1:0]   w_shift;
    logic   [DEPTH-1:0]   w_wr;

    t_cell_ctl            w_ctl;
    t_entry               w_in_ent;
    logic                 w_acc;
    logic                 w_out_free;
    logic                 w_enq_ok;
    logic                 w_can_go;
    logic                 w_deq_start;
    logic                 w_deq_done;

    assign w_vld[DEPTH]     = 1'b0;
    assign w_ent[DEPTH]     = '0;
    assign w_tok_vld[DEPTH] = 1'b0;
    assign w_tok[DEPTH]     = '0;
    assign w_tok_idx[DEPTH] = '0;

    assign w_in_ent.id     = i_order_id;
    assign w_in_ent.prio   = i_entry_priority;
    assign w_in_ent.tstamp = i_entry_time;

    // A new command is taken only when the result register is free or drains now.
    assign w_out_free = !r_ovld || !i_stall;
    assign o_stall    = (r_state != S_IDLE) || !w_out_free;
    assign w_acc      = i_valid && !o_stall;

    assign w_enq_ok    = w_acc && (i_cmd == CMD_ENQ) && (r_count != CNT_FULL);
    assign w_can_go    = w_acc && (i_cmd == CMD_CANCEL) && w_pre[DEPTH-1];
    assign w_deq_start = w_acc && (i_cmd == CMD_DEQ) && (r_count != '0);
    assign w_deq_done  = (r_state == S_SCAN) && (r_step == r_count) && w_out_free;

    assign w_ctl.tok_load = w_deq_start;
    assign w_ctl.tok_step = (r_state == S_SCAN) && (r_step != r_count);
    assign w_ctl.id       = i_order_id;

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            localparam logic [IDX_W-1:0] KI = IDX_W'(k);
            localparam logic [CNT_W-1:0] KC = CNT_W'(k);

            // First match in insertion order: everything from it onward shifts down.
            if (k == 0) begin : g_first
                assign w_pre[k] = w_match[k];
            end else begin : g_rest
                assign w_pre[k] = w_pre[k-1] || w_match[k];
            end

            assign w_wr[k]    = w_enq_ok && (r_count == KC);
            assign w_shift[k] = (w_can_go && w_pre[k]) ||
                                (w_deq_done && (KI >= w_tok_idx[0]));

            tlpq_cell #(
                .IDX_W    (IDX_W),
                .CELL_IDX (k)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_wr          (w_wr[k]),
                .i_wr_ent      (w_in_ent),
                .i_shift       (w_shift[k]),
                .i_nxt_vld     (w_vld[k+1]),
                .i_nxt_ent     (w_ent[k+1]),
                .i_nxt_tok_vld (w_tok_vld[k+1]),
                .i_nxt_tok     (w_tok[k+1]),
                .i_nxt_tok_idx (w_tok_idx[k+1]),
                .o_vld         (w_vld[k]),
                .o_ent         (w_ent[k]),
                .o_match       (w_match[k]),
                .o_tok_vld     (w_tok_vld[k]),
                .o_tok         (w_tok[k]),
                .o_tok_idx     (w_tok_idx[k])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_enq_ok) begin
            n_count = r_count + 1'b1;
        end else if (w_can_go || w_deq_done) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_step  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_count <= n_count;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_out  <= '0;
                        r_live <= LIVE_W'(n_count);
                        case (t_cmd'(i_cmd))
                            CMD_ENQ: begin
                                r_ovld <= 1'b1;
                                if (w_enq_ok) begin
                                    r_status <= ST_OK;
                                end else begin
                                    r_status <= ST_FULL;
                                end
                            end
                            CMD_DEQ: begin
                                if (w_deq_start) begin
                                    // The result comes when the scan ends.
                                    r_ovld  <= 1'b0;
                                    r_step  <= CNT_W'(1);
                                    r_state <= S_SCAN;
                                end else begin
                                    r_ovld   <= 1'b1;
                                    r_status <= ST_EMPTY;
                                end
                            end
                            CMD_CANCEL: begin
                                r_ovld <= 1'b1;
                                if (w_can_go) begin
                                    r_status <= ST_OK;
                                end else begin
                                    r_status <= ST_NOT_FOUND;
                                end
                            end
                            default: begin
                                r_ovld   <= 1'b1;
                                r_status <= ST_OK;
                            end
                        endcase
                    end else if (w_out_free) begin
                        r_ovld <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (w_ctl.tok_step) begin
                        r_step <= r_step + 1'b1;
                    end else if (w_deq_done) begin
                        r_out    <= w_tok[0];
                        r_live   <= LIVE_W'(n_count);
                        r_status <= ST_OK;
                        r_ovld   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_ovld;
    assign o_status       = r_status;
    assign o_out_id       = r_out.id;
    assign o_out_priority = r_out.prio;
    assign o_out_time     = r_out.tstamp;
    assign o_live_count   = r_live;

    // Valid cells and the live count must agree at all times.
    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_vld[DEPTH-1:0]) == r_count)
        else $error("live count differs from number of valid cells");

    // A full report can only come from a queue holding DEPTH entries.
    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && (r_status == ST_FULL)) |-> (r_count == CNT_FULL))
        else $error("full reported while queue has room");

    // A scan never runs on an empty queue.
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_count != '0))
        else $error("dequeue scan on empty queue");

    // A finished dequeue always delivers a live entry from the chain head.
    a_deq_token_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_deq_done |-> w_tok_vld[0])
        else $error("dequeue finished without a valid best entry");

endmodule

`default_nettype wire
